// File: rtl/bbms_pkg.sv
// Shared types, constants and helpers for the bouncing ball motion step block.
package bbms_pkg;

	localparam int BALL_COUNT = 4;
	localparam int CNT_W      = $clog2(BALL_COUNT + 1);

	localparam int ID_W    = 2;
	localparam int POS_W   = 12;
	localparam int SPX_W   = 5;
	localparam int SPY_W   = 20;
	localparam int WAIT_W  = 7;
	localparam int GRAV_W  = 12;
	localparam int DAMP_W  = 9;
	localparam int LOADX_W = 4;
	localparam int CFG_W   = 12;

	localparam logic signed [31:0] SPEED_MAX = 32'sd524287;
	localparam logic signed [31:0] SPEED_MIN = -32'sd524288;

	typedef enum logic [1:0] {
		REG_GRAVITY = 2'd0,
		REG_RIGHT   = 2'd1,
		REG_BOTTOM  = 2'd2,
		REG_DAMPING = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic               op;
		logic [ID_W-1:0]    ball_index;
		logic [LOADX_W-1:0] start_speed_x;
		logic [WAIT_W-1:0]  start_delay;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]  ball_id;
		logic [POS_W-1:0] pos_x_out;
		logic [POS_W-1:0] pos_y_out;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic [GRAV_W-1:0] gravity_q8;
		logic [POS_W-1:0]  right_limit;
		logic [POS_W-1:0]  bottom_limit;
		logic [DAMP_W-1:0] damping_q8;
	} cfg_t;

	typedef struct packed {
		logic step;    // tick: move the ball, capture its position
		logic bounce;  // after a tick step: damp a floor hit
		logic load;    // restart this ball
		logic shift;   // result slot takes the neighbor's slot
	} cell_ctrl_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} slot_t;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	function automatic logic signed [SPY_W-1:0] sat_speed(input logic signed [31:0] v);
		logic signed [SPY_W-1:0] r;
		if (v > SPEED_MAX)
			r = SPY_W'(SPEED_MAX);
		else if (v < SPEED_MIN)
			r = SPY_W'(SPEED_MIN);
		else
			r = SPY_W'(v);
		return r;
	endfunction

endpackage

// File: rtl/bbms_cell.sv
// One ball: its motion state, its update logic and its slot in the result chain.
module bbms_cell import bbms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  cfg_t               cfg,
	input  logic [LOADX_W-1:0] load_speed_x,
	input  logic [WAIT_W-1:0]  load_delay,
	input  slot_t              slot_in,
	output slot_t              slot_out
);

	logic [POS_W-1:0]         x_q, y_q;
	logic signed [SPX_W-1:0]  sx_q;
	logic signed [SPY_W-1:0]  sy_q;
	logic [WAIT_W-1:0]        wait_q;
	logic                     floor_q;
	slot_t                    slot_q;

	logic [POS_W-1:0]         x_n, y_n;
	logic signed [SPX_W-1:0]  sx_n;
	logic signed [SPY_W-1:0]  sy_n;
	logic [WAIT_W-1:0]        wait_n;
	logic                     floor_n;

	logic signed [SPY_W:0]    sy_sum;
	logic signed [SPY_W-1:0]  sy_g;
	logic signed [21:0]       sum_q8;
	logic signed [13:0]       ny, nx;

	// floor damping
	logic signed [29:0]       prod;
	logic signed [30:0]       neg;
	logic signed [22:0]       quot;

	always_comb begin
		sy_sum = {sy_q[SPY_W-1], sy_q} + $signed({9'b0, cfg.gravity_q8});
		sy_g   = sat_speed(32'(sy_sum));
		sum_q8 = $signed({2'b0, y_q, 8'b0}) + {{2{sy_g[SPY_W-1]}}, sy_g};
		// truncate toward zero
		ny     = sum_q8[21:8] + 14'((sum_q8[21] && (|sum_q8[7:0])) ? 1 : 0);
		nx     = $signed({2'b0, x_q}) + {{9{sx_q[SPX_W-1]}}, sx_q};

		x_n     = x_q;
		y_n     = y_q;
		sx_n    = sx_q;
		sy_n    = sy_q;
		wait_n  = wait_q;
		floor_n = 1'b0;
		if (wait_q > WAIT_W'(1)) begin
			wait_n = wait_q - WAIT_W'(1);
		end else begin
			wait_n = '0;
			sy_n   = sy_g;
			if (nx < 0) begin
				x_n  = '0;
				sx_n = -sx_q;
			end else if (nx > $signed({2'b0, cfg.right_limit})) begin
				x_n  = cfg.right_limit;
				sx_n = -sx_q;
			end else begin
				x_n = nx[POS_W-1:0];
			end
			if (ny < 0) begin
				y_n  = '0;
				sy_n = '0;
			end else if (ny > $signed({2'b0, cfg.bottom_limit})) begin
				y_n     = cfg.bottom_limit;
				floor_n = 1'b1;
			end else begin
				y_n = ny[POS_W-1:0];
			end
		end

		prod = sy_q * $signed({1'b0, cfg.damping_q8});
		neg  = -{prod[29], prod};
		quot = neg[30:8] + 23'((neg[30] && (|neg[7:0])) ? 1 : 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			wait_q  <= '0;
			floor_q <= 1'b0;
		end else if (ctrl.load) begin
			x_q     <= '0;
			y_q     <= '0;
			sx_q    <= $signed({1'b0, load_speed_x});
			sy_q    <= '0;
			wait_q  <= load_delay;
			floor_q <= 1'b0;
		end else if (ctrl.step) begin
			x_q     <= x_n;
			y_q     <= y_n;
			sx_q    <= sx_n;
			sy_q    <= sy_n;
			wait_q  <= wait_n;
			floor_q <= floor_n;
		end else if (ctrl.bounce) begin
			if (floor_q)
				sy_q <= sat_speed(32'(quot));
			floor_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step)
			slot_q <= '{pos_x: x_n, pos_y: y_n};
		else if (ctrl.shift)
			slot_q <= slot_in;
	end

	assign slot_out = slot_q;

endmodule

// File: rtl/bouncing_ball_motion_step.sv
// Top level of the bouncing ball motion step: ball cells, result chain and control.
//
// A row of BALL_COUNT cells each holds one ball. A load item restarts one ball and gives
// no result. A tick item steps all balls at once in its transfer cycle; in the next cycle
// any ball that hit the floor has its vertical speed damped (one 20x9 multiplier per
// cell). Each cell drops its new position into a result slot, and the slots form a shift
// chain that moves one position toward the output on every result transfer, ball 0
// first, the last ball marked. A new item is taken only once the chain has drained, so the
// block takes no item while a tick's results are pending or stalled at the output; a load
// leaves the chain empty. The result chain length sets the tick rate.
// Configuration writes are registered and are meant for an idle block.
module bouncing_ball_motion_step import bbms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// item channel
	input  logic             item_valid,
	output logic             item_ready,
	input  in_item_t         item,
	// result channel
	output logic             pos_valid,
	input  logic             pos_ready,
	output out_item_t        pos,
	// configuration
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cfg_t             cfg_q;
	logic [CNT_W-1:0] cnt_q;     // results still in the chain
	logic             bounce_q;  // damping cycle after a tick

	logic item_xfer, pos_xfer, tick_xfer, load_xfer;

	slot_t      slot [BALL_COUNT];
	cell_ctrl_t ctrl [BALL_COUNT];

	assign item_ready = !bounce_q && (cnt_q == '0);
	assign item_xfer  = item_valid && item_ready;
	assign tick_xfer  = item_xfer && (item.op == OP_TICK);
	assign load_xfer  = item_xfer && (item.op == OP_LOAD);
	assign pos_valid  = (cnt_q != '0);
	assign pos_xfer   = pos_valid && pos_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity_q8   <= GRAV_W'(1873);
			cfg_q.right_limit  <= POS_W'(592);
			cfg_q.bottom_limit <= POS_W'(352);
			cfg_q.damping_q8   <= DAMP_W'(250);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRAVITY: cfg_q.gravity_q8   <= cfg_wdata[GRAV_W-1:0];
				REG_RIGHT:   cfg_q.right_limit  <= cfg_wdata[POS_W-1:0];
				REG_BOTTOM:  cfg_q.bottom_limit <= cfg_wdata[POS_W-1:0];
				REG_DAMPING: cfg_q.damping_q8   <= cfg_wdata[DAMP_W-1:0];
				default: ;
			endcase
		end
	end

	// tick sequencing: step, then damp while the chain starts draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			bounce_q <= 1'b0;
		end else begin
			bounce_q <= tick_xfer;
			if (tick_xfer)
				cnt_q <= CNT_W'(BALL_COUNT);
			else if (pos_xfer)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// cell row; each slot feeds its lower neighbor
	for (genvar i = 0; i < BALL_COUNT; i++) begin : g_cell
		slot_t nb;

		assign ctrl[i] = '{
			step:   tick_xfer,
			bounce: bounce_q,
			load:   load_xfer && (int'(item.ball_index) == i),
			shift:  pos_xfer
		};

		if (i == BALL_COUNT - 1) begin : g_tail
			assign nb = '0;
		end else begin : g_link
			assign nb = slot[i+1];
		end

		bbms_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl[i]),
			.cfg          (cfg_q),
			.load_speed_x (item.start_speed_x),
			.load_delay   (item.start_delay),
			.slot_in      (nb),
			.slot_out     (slot[i])
		);
	end

	// head of the chain is the next result; its ball number follows from the count
	logic [CNT_W-1:0] head_id;
	assign head_id = CNT_W'(BALL_COUNT) - cnt_q;

	assign pos = '{
		ball_id:   head_id[ID_W-1:0],
		pos_x_out: slot[0].pos_x,
		pos_y_out: slot[0].pos_y,
		last:      (cnt_q == CNT_W'(1))
	};

	// checks
	a_tick_fills: assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer |=> (cnt_q == CNT_W'(BALL_COUNT)) && bounce_q)
		else $error("tick did not fill the result chain");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !pos_valid)
		else $error("item taken while results pending");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_xfer && pos.last) |=> !pos_valid)
		else $error("results remain after last transfer");

	a_bounce_once: assert property (@(posedge clk) disable iff (!arst_n)
		bounce_q |=> !bounce_q)
		else $error("damping cycle repeated");

endmodule

// File: tb/sv/bbms_checker.sv
// Checker for the bouncing ball motion step: ball predictor and position scoreboard.
`timescale 1ns / 100ps

module bbms_checker import bbms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  in_item_t         item,
	input  logic             pos_valid,
	input  logic             pos_ready,
	input  out_item_t        pos,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               pending,
	output int               errors
);

	// predicted ball state and register copy
	cfg_t                     regs;
	logic [POS_W-1:0]         ball_px   [BALL_COUNT];
	logic [POS_W-1:0]         ball_py   [BALL_COUNT];
	logic signed [SPX_W-1:0]  ball_vx   [BALL_COUNT];
	logic signed [SPY_W-1:0]  ball_vy   [BALL_COUNT];
	logic [WAIT_W-1:0]        ball_hold [BALL_COUNT];
	out_item_t                positions_due[$];
	int                       mismatch_cnt;

	function automatic longint clip_vy(input longint v);
		longint r;
		r = v;
		if (v > 64'sd524287)
			r = 64'sd524287;
		else if (v < -64'sd524288)
			r = -64'sd524288;
		return r;
	endfunction

	// one ball, one tick: release delay, gravity, move, walls
	task automatic step_ball(input int b);
		longint vy;
		longint nx;
		longint ny;
		if (ball_hold[b] > 1) begin
			ball_hold[b] = ball_hold[b] - 1'b1;
			return;
		end
		ball_hold[b] = '0;
		vy = clip_vy(longint'(ball_vy[b]) + longint'(regs.gravity_q8));
		// signed division truncates toward zero
		ny = (longint'(ball_py[b]) * 256 + vy) / 256;
		nx = longint'(ball_px[b]) + longint'(ball_vx[b]);
		if (nx < 0) begin
			nx = 0;
			ball_vx[b] = -ball_vx[b];
		end
		if (nx > longint'(regs.right_limit)) begin
			nx = longint'(regs.right_limit);
			ball_vx[b] = -ball_vx[b];
		end
		if (ny < 0) begin
			ny = 0;
			vy = 0;
		end
		if (ny > longint'(regs.bottom_limit)) begin
			ny = longint'(regs.bottom_limit);
			vy = clip_vy(-(vy * longint'(regs.damping_q8)) / 256);
		end
		ball_px[b] = nx[POS_W-1:0];
		ball_py[b] = ny[POS_W-1:0];
		ball_vy[b] = vy[SPY_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			regs = '{gravity_q8: GRAV_W'(1873), right_limit: POS_W'(592),
				bottom_limit: POS_W'(352), damping_q8: DAMP_W'(250)};
			for (int b = 0; b < BALL_COUNT; b++) begin
				ball_px[b]   = '0;
				ball_py[b]   = '0;
				ball_vx[b]   = '0;
				ball_vy[b]   = '0;
				ball_hold[b] = '0;
			end
			positions_due.delete();
			mismatch_cnt = 0;
			pending <= 0;
			errors  <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_GRAVITY: regs.gravity_q8   = cfg_wdata[GRAV_W-1:0];
					REG_RIGHT:   regs.right_limit  = cfg_wdata[POS_W-1:0];
					REG_BOTTOM:  regs.bottom_limit = cfg_wdata[POS_W-1:0];
					REG_DAMPING: regs.damping_q8   = cfg_wdata[DAMP_W-1:0];
					default: ;
				endcase
			end

			if (item_valid && item_ready) begin
				if (item.op == OP_LOAD) begin
					ball_px[item.ball_index]   = '0;
					ball_py[item.ball_index]   = '0;
					ball_vx[item.ball_index]   = SPX_W'(item.start_speed_x);
					ball_vy[item.ball_index]   = '0;
					ball_hold[item.ball_index] = item.start_delay;
				end else begin
					for (int b = 0; b < BALL_COUNT; b++) begin
						step_ball(b);
						want.ball_id   = ID_W'(b);
						want.pos_x_out = ball_px[b];
						want.pos_y_out = ball_py[b];
						want.last      = (b == BALL_COUNT - 1);
						positions_due.push_back(want);
					end
				end
			end

			if (pos_valid && pos_ready) begin
				if (positions_due.size() == 0) begin
					$error("result for ball %0d with nothing expected", pos.ball_id);
					mismatch_cnt++;
				end else begin
					want = positions_due.pop_front();
					if (pos.ball_id !== want.ball_id) begin
						$error("ball_id: expected %0d, got %0d", want.ball_id, pos.ball_id);
						mismatch_cnt++;
					end
					if (pos.pos_x_out !== want.pos_x_out) begin
						$error("pos_x_out: expected %0d, got %0d", want.pos_x_out,
							pos.pos_x_out);
						mismatch_cnt++;
					end
					if (pos.pos_y_out !== want.pos_y_out) begin
						$error("pos_y_out: expected %0d, got %0d", want.pos_y_out,
							pos.pos_y_out);
						mismatch_cnt++;
					end
					if (pos.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, pos.last);
						mismatch_cnt++;
					end
				end
			end

			pending <= positions_due.size();
			errors  <= mismatch_cnt;
		end
	end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the bouncing ball motion step: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
	import bbms_pkg::*;

	// longest run of cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT = 3000;
	// settle time after the last result; a load can still be in flight
	localparam int SETTLE_CYCLES = 8;

	logic             clk;
	logic             arst_n     = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	in_item_t         item       = '0;
	logic             pos_valid;
	logic             pos_ready  = 1'b0;
	out_item_t        pos;
	logic             cfg_we     = 1'b0;
	reg_idx_t         cfg_index  = REG_GRAVITY;
	logic [CFG_W-1:0] cfg_wdata  = '0;

	int pending;
	int errors;

	// quiet = 1 turns off random idling on both channels
	bit quiet = 1'b0;
	int idle_cycles = 0;
	int n_ticks     = 0;
	int n_loads     = 0;
	int n_results   = 0;
	int n_settings  = 0;

	bouncing_ball_motion_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.pos_valid (pos_valid),
		.pos_ready (pos_ready),
		.pos       (pos),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	bbms_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.pos_valid (pos_valid),
		.pos_ready (pos_ready),
		.pos       (pos),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side backpressure: ready drops in about 38% of cycles unless quiet.
	always @(posedge clk) begin
		pos_ready <= quiet || ($urandom_range(99) >= 38);
	end

	// Watchdog: counts cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (pos_valid && pos_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (pos_valid && pos_ready)
			n_results <= n_results + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d positions outstanding",
				idle_cycles, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// One item transfer. Valid may stay high into the next item, so a gap is the only
	// place valid is lowered; that keeps one nonblocking write per signal per step.
	task automatic send(input in_item_t it);
		if (!quiet && $urandom_range(99) < 38) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 38);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		if (it.op == OP_LOAD)
			n_loads++;
		else
			n_ticks++;
	endtask

	task automatic load(input int idx, input int spx, input int dly);
		in_item_t it;
		it.op            = OP_LOAD;
		it.ball_index    = ID_W'(idx);
		it.start_speed_x = LOADX_W'(spx);
		it.start_delay   = WAIT_W'(dly);
		send(it);
	endtask

	// Tick with junk in the unused fields; the block must ignore them.
	task automatic tick();
		in_item_t it;
		it               = in_item_t'($urandom);
		it.op            = OP_TICK;
		send(it);
	endtask

	// Random restart: mostly short delays so balls get moving, now and then a long one.
	task automatic random_load();
		int dly;
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			dly = $urandom_range(3);
		else if (pick < 90)
			dly = $urandom_range(20, 4);
		else
			dly = $urandom_range(127);
		load($urandom_range(BALL_COUNT - 1), $urandom_range(15), dly);
	endtask

	// Stop sending and wait for every expected position, then let a trailing load settle.
	// The first edge lets the checker's count catch up with the last item transfer.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back; only called on an idle block.
	task automatic set_regs(input logic [CFG_W-1:0] grav, input logic [CFG_W-1:0] right,
			input logic [CFG_W-1:0] bottom, input logic [CFG_W-1:0] damp);
		reg_idx_t         ids  [4];
		logic [CFG_W-1:0] vals [4];
		ids  = '{REG_GRAVITY, REG_RIGHT, REG_BOTTOM, REG_DAMPING};
		vals = '{grav, right, bottom, damp};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= ids[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	initial begin
		in_item_t junk_tick;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a small arena so every wall gets hit within a few ticks.
		// Gravity stays at its reset value; damping above unity makes the floor bounce
		// throw the ball past the top wall.
		set_regs(12'd1873, 12'd30, 12'd20, 12'd300);
		load(0, 15, 0);      // fastest ball, released on the first tick
		load(1, 0, 1);       // delay of one also releases at once
		load(2, 7, 2);       // one tick of waiting
		load(3, 8, 127);     // longest wait: reports the origin until it is restarted
		// tick with every ignored field bit set
		junk_tick.op            = OP_TICK;
		junk_tick.ball_index    = '1;
		junk_tick.start_speed_x = '1;
		junk_tick.start_delay   = '1;
		send(junk_tick);
		// enough ticks for right wall, left wall, floor and top wall
		repeat (14) tick();
		load(3, 15, 0);      // restart a waiting ball mid-flight of the others
		repeat (3) tick();
		drain();

		// Random part: eight register settings, about fifty items each.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_regs(12'd1873, 12'd592, 12'd352, 12'd250);  // reset values
				1: set_regs(12'd0, 12'd0, 12'd0, 12'd0);           // all minimum
				2: set_regs(12'd4095, 12'd4095, 12'd4095, 12'd511); // all maximum
				3: set_regs(12'd4095, 12'd40, 12'd100, 12'd511);
				4: set_regs(12'd600, 12'd100, 12'd60, 12'd256);    // lossless floor
				5: set_regs(12'($urandom_range(4095)), 12'($urandom_range(300, 8)),
					12'($urandom_range(300, 8)), 12'($urandom_range(256)));
				// raw write data: damping bits above its width must be dropped
				6: set_regs(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
				default: set_regs(12'd2000, 12'd16, 12'd0, 12'd511);
			endcase
			// one whole phase with no idling on either side
			quiet = (phase == 3);
			for (int n = 0; n < 51; n++) begin
				if ($urandom_range(99) < 28)
					random_load();
				else
					tick();
				// hold off new items until the block has delivered everything
				if (phase == 5 && n == 25)
					drain();
			end
			drain();
		end
		quiet = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d ticks and %0d restarts under %0d register settings",
			n_ticks, n_loads, n_settings);
		$display("%0d ball positions checked, %0d mismatches", n_results, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bbms_pkg.sv
rtl/bbms_cell.sv
rtl/bouncing_ball_motion_step.sv
tb/sv/bbms_checker.sv
tb/sv/tb.sv
